### design/prim_minimum_spanning_tree_core_macros.svh
// Assertion shorthands for the spanning tree engine checkers.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef PRIM_MINIMUM_SPANNING_TREE_CORE_MACROS_SVH
`define PRIM_MINIMUM_SPANNING_TREE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PRIM_MST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PRIM_MST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/prim_mst_pkg.sv
`timescale 1ns / 1ps

package prim_mst_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;

  // Fixed port widths
  localparam int OP_W          = 2;
  localparam int NODE_W        = 6;
  localparam int WEIGHT_PORT_W = 16;
  localparam int TOTAL_W       = 22;
  localparam int VCOUNT_W      = 7;
  localparam int START_W       = 6;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 7;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
  localparam logic [START_W-1:0]  START_RESET  = 6'd0;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT = 1'b0,
    CFG_START_VERTEX = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_PUSH,
    ST_RELAX,
    ST_RELAX_TAIL
  } state_e;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic acc_clear;
    logic acc_run;
    logic pend_stall;
    logic found;
  } stat_t;

  // Strobes from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic clr_we;
    logic issue_scan;
    logic issue_relax;
    logic scan_first;
    logic push_en;
  } ctl_t;

endpackage

### design/prim_minimum_spanning_tree_core.sv
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// --------+----------------------+--------------------------------------------
// in      | in_valid / in_ready  | operation, node_a, node_b, edge_weight
// out     | out_valid / out_ready| visited_vertex, has_parent, parent_vertex,
//         |                      | tree_edge_weight, tree_total, last_of_run
// cfg     | cfg_we (no wait)     | cfg_index, cfg_data
//
// Add edge: one cycle per word, back to back. Clear: the whole edge matrix is
// zeroed, one edge entry swept per cycle; the same sweep runs right after reset,
// with in_ready low throughout.
// Run: with n vertices in use, each step is a scan pass and, when a vertex is
// found, a relax pass over the n vertices through the one shared compare unit and
// the single read port of the edge and key memories.
// A stalled out channel holds the sequencer in its push step; the output
// register and one pending result let the run continue while a word waits.
module prim_minimum_spanning_tree_core #(
  parameter int MAX_VERTICES = prim_mst_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = prim_mst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // input channel
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [prim_mst_pkg::OP_W-1:0]                 in_operation,
  input  logic [prim_mst_pkg::NODE_W-1:0]               in_node_a,
  input  logic [prim_mst_pkg::NODE_W-1:0]               in_node_b,
  input  logic signed [prim_mst_pkg::WEIGHT_PORT_W-1:0] in_edge_weight,
  // result channel
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [prim_mst_pkg::NODE_W-1:0]               out_visited_vertex,
  output logic                                          out_has_parent,
  output logic [prim_mst_pkg::NODE_W-1:0]               out_parent_vertex,
  output logic signed [prim_mst_pkg::WEIGHT_PORT_W-1:0] out_tree_edge_weight,
  output logic signed [prim_mst_pkg::TOTAL_W-1:0]       out_tree_total,
  output logic                                          out_last_of_run,
  // configuration
  input  logic                                          cfg_we,
  input  logic [prim_mst_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [prim_mst_pkg::CFG_DATA_W-1:0]           cfg_data
);

  import prim_mst_pkg::*;

  localparam int VW         = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int AW         = 2 * VW;
  localparam int EDGE_DEPTH = 1 << AW;
  localparam int EW         = WEIGHT_BITS + 1;             // present bit + weight
  localparam int KW         = WEIGHT_BITS + VW;            // parent + key
  localparam int EXT_W      = (WEIGHT_BITS > WEIGHT_PORT_W) ? WEIGHT_BITS : WEIGHT_PORT_W;
  localparam int SUM_W      = (WEIGHT_BITS > TOTAL_W) ? WEIGHT_BITS : TOTAL_W;
  localparam logic [VCOUNT_W-1:0] MAXV     = VCOUNT_W'(MAX_VERTICES);
  localparam logic [NODE_W:0]     NODE_LIM = (NODE_W + 1)'(MAX_VERTICES);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [VCOUNT_W-1:0] vcount_r;
  logic [START_W-1:0]  start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
      start_r  <= START_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_VERTEX_COUNT: vcount_r <= cfg_data[VCOUNT_W-1:0];
        CFG_START_VERTEX: start_r  <= cfg_data[START_W-1:0];
      endcase
    end
  end

  // Clamp the count into 1..MAX_VERTICES; a root at or above it gives an empty run
  logic [VCOUNT_W-1:0] n_cnt;
  logic [VW-1:0]       last_idx;
  logic [VW-1:0]       s_idx;
  logic                run_ok;

  always_comb begin
    priority if (vcount_r == '0) begin
      n_cnt = VCOUNT_W'(1);
    end else if (vcount_r > MAXV) begin
      n_cnt = MAXV;
    end else begin
      n_cnt = vcount_r;
    end
    last_idx = VW'(n_cnt - 1'b1);
    s_idx    = VW'(start_r);
    run_ok   = VCOUNT_W'(start_r) < n_cnt;
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  ctl_t  ctl;
  stat_t stat;
  logic  in_fire, acc_clear, acc_add, acc_run;

  logic [EXT_W-1:0]       w_raw_ext;
  logic [WEIGHT_BITS-1:0] w_in;
  logic [VW-1:0]          na, nb;
  logic [AW-1:0]          add_addr;

  always_comb begin
    in_fire   = in_valid && ctl.in_ready;
    acc_clear = in_fire && (in_operation == OP_CLEAR);
    acc_run   = in_fire && (in_operation == OP_RUN) && run_ok;
    // drop adds with an endpoint outside the matrix
    acc_add   = in_fire && (in_operation == OP_ADD) &&
                ({1'b0, in_node_a} < NODE_LIM) && ({1'b0, in_node_b} < NODE_LIM);
    // the weight word is taken as WEIGHT_BITS two's complement bits
    w_raw_ext = EXT_W'($unsigned(in_edge_weight));
    w_in      = w_raw_ext[WEIGHT_BITS-1:0];
    na        = VW'(in_node_a);
    nb        = VW'(in_node_b);
    // undirected: keep only the upper triangle, row is the lower endpoint
    add_addr  = (na < nb) ? {na, nb} : {nb, na};
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [VW-1:0] idx;
  logic [AW-1:0] clr_addr;

  prim_mst_ctrl #(
    .VW (VW),
    .AW (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .last_idx (last_idx),
    .idx      (idx),
    .clr_addr (clr_addr),
    .ctl      (ctl)
  );

  // ---------------------------------------------------------------------------
  // Memories: edge matrix and per-vertex key/parent records
  // ---------------------------------------------------------------------------
  logic                          found_r;
  logic [VW-1:0]                 best_u_r;
  logic signed [WEIGHT_BITS-1:0] best_key_r;
  logic [VW-1:0]                 best_par_r;

  logic          rd_scan_r, rd_relax_r;
  logic [VW-1:0] rd_idx_r;

  logic [AW-1:0] rx_addr;
  logic          edge_we;
  logic [AW-1:0] edge_waddr;
  logic [EW-1:0] edge_wdata;
  logic [EW-1:0] edge_rd;

  logic          key_we;
  logic [VW-1:0] key_waddr;
  logic [KW-1:0] key_wdata;
  logic [KW-1:0] key_rd;

  logic                          e_present;
  logic signed [WEIGHT_BITS-1:0] e_w;
  logic signed [WEIGHT_BITS-1:0] k_key;
  logic [VW-1:0]                 k_par;
  logic                          kw_relax;

  always_comb begin
    rx_addr    = (best_u_r < idx) ? {best_u_r, idx} : {idx, best_u_r};
    edge_we    = ctl.clr_we || acc_add;
    edge_waddr = ctl.clr_we ? clr_addr : add_addr;
    edge_wdata = ctl.clr_we ? '0 : {1'b1, w_in};
    // seed the root record at run start, otherwise write relaxed neighbors
    key_we     = acc_run || kw_relax;
    key_waddr  = acc_run ? s_idx : rd_idx_r;
    key_wdata  = acc_run ? '0 : {best_u_r, e_w};
  end

  prim_mst_ram #(
    .WIDTH (EW),
    .DEPTH (EDGE_DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (rx_addr),
    .rdata (edge_rd)
  );

  prim_mst_ram #(
    .WIDTH (KW),
    .DEPTH (MAX_VERTICES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (idx),
    .rdata (key_rd)
  );

  assign e_present = edge_rd[WEIGHT_BITS];
  assign e_w       = edge_rd[WEIGHT_BITS-1:0];
  assign k_key     = key_rd[WEIGHT_BITS-1:0];
  assign k_par     = key_rd[KW-1:WEIGHT_BITS];

  // Read data lands in the cycle after the address; track which pass it belongs to
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_scan_r  <= 1'b0;
      rd_relax_r <= 1'b0;
    end else begin
      rd_scan_r  <= ctl.issue_scan;
      rd_relax_r <= ctl.issue_relax;
    end
    rd_idx_r <= idx;
  end

  // ---------------------------------------------------------------------------
  // Shared compare unit
  // ---------------------------------------------------------------------------
  logic lt;

  prim_mst_cmp #(
    .W (WEIGHT_BITS)
  ) u_cmp (
    .sel_relax (rd_relax_r),
    .scan_a    (k_key),
    .scan_b    (best_key_r),
    .relax_a   (e_w),
    .relax_b   (k_key),
    .lt        (lt)
  );

  // ---------------------------------------------------------------------------
  // Per-vertex flags
  // ---------------------------------------------------------------------------
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [MAX_VERTICES-1:0] fin_r, fin_nxt;    // key is finite
  logic [MAX_VERTICES-1:0] pv_r, pv_nxt;      // joined through an edge
  logic                    cand, found_nxt, push_load;

  always_comb begin
    // strict less-than on keys keeps the lowest index on ties
    cand     = rd_scan_r && !visited_r[rd_idx_r] && fin_r[rd_idx_r] && (!found_r || lt);
    kw_relax = rd_relax_r && e_present && !visited_r[rd_idx_r] &&
               (!fin_r[rd_idx_r] || lt);
    found_nxt = ctl.scan_first ? 1'b0 : (cand ? 1'b1 : found_r);
    push_load = ctl.push_en && found_r;
  end

  always_comb begin
    visited_nxt = visited_r;
    fin_nxt     = fin_r;
    pv_nxt      = pv_r;
    if (acc_run) begin
      visited_nxt    = '0;
      fin_nxt        = '0;
      pv_nxt         = '0;
      fin_nxt[s_idx] = 1'b1;
    end else begin
      if (push_load) begin
        visited_nxt[best_u_r] = 1'b1;
      end
      if (kw_relax) begin
        fin_nxt[rd_idx_r] = 1'b1;
        pv_nxt[rd_idx_r]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      fin_r     <= '0;
      pv_r      <= '0;
      found_r   <= 1'b0;
    end else begin
      visited_r <= visited_nxt;
      fin_r     <= fin_nxt;
      pv_r      <= pv_nxt;
      found_r   <= found_nxt;
    end
  end

  // Best candidate of the current scan
  always_ff @(posedge clk) begin
    if (cand) begin
      best_u_r   <= rd_idx_r;
      best_key_r <= k_key;
      best_par_r <= k_par;
    end
  end

  // ---------------------------------------------------------------------------
  // Running total and result staging
  // ---------------------------------------------------------------------------
  // A result is parked in the pending slot until the next scan tells whether it
  // is the last of the run, then moves to the output register.
  logic signed [TOTAL_W-1:0] total_r, total_nxt;
  logic signed [SUM_W-1:0]   key_ext, tot_ext, tot_sum;
  logic signed [EXT_W-1:0]   key_w_ext;
  logic                      best_has_par;

  always_comb begin
    best_has_par = pv_r[best_u_r];
    key_ext      = SUM_W'(best_key_r);
    tot_ext      = SUM_W'(total_r);
    tot_sum      = tot_ext + (best_has_par ? key_ext : SUM_W'(0));
    total_nxt    = tot_sum[TOTAL_W-1:0];
    key_w_ext    = EXT_W'(best_key_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (acc_run) begin
      total_r <= '0;
    end else if (push_load) begin
      total_r <= total_nxt;
    end
  end

  logic                            pend_vld_r;
  logic [NODE_W-1:0]               pend_vertex_r;
  logic                            pend_has_par_r;
  logic [NODE_W-1:0]               pend_par_r;
  logic signed [WEIGHT_PORT_W-1:0] pend_w_r;
  logic signed [TOTAL_W-1:0]       pend_tot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else if (ctl.push_en) begin
      pend_vld_r <= found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_load) begin
      pend_vertex_r  <= NODE_W'(best_u_r);
      pend_has_par_r <= best_has_par;
      pend_par_r     <= best_has_par ? NODE_W'(best_par_r) : '0;
      pend_w_r       <= best_has_par ? key_w_ext[WEIGHT_PORT_W-1:0] : '0;
      pend_tot_r     <= total_nxt;
    end
  end

  // Output register
  logic out_valid_r, out_valid_nxt, out_load;
  logic [NODE_W-1:0]               out_vertex_r;
  logic                            out_has_par_r;
  logic [NODE_W-1:0]               out_par_r;
  logic signed [WEIGHT_PORT_W-1:0] out_w_r;
  logic signed [TOTAL_W-1:0]       out_tot_r;
  logic                            out_last_r;

  always_comb begin
    out_load      = ctl.push_en && pend_vld_r;
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vertex_r  <= pend_vertex_r;
      out_has_par_r <= pend_has_par_r;
      out_par_r     <= pend_par_r;
      out_w_r       <= pend_w_r;
      out_tot_r     <= pend_tot_r;
      out_last_r    <= !found_r;
    end
  end

  always_comb begin
    stat.acc_clear  = acc_clear;
    stat.acc_run    = acc_run;
    // hold the push while the parked result cannot move out
    stat.pend_stall = pend_vld_r && out_valid_r && !out_ready;
    stat.found      = found_r;
  end

  assign in_ready             = ctl.in_ready;
  assign out_valid            = out_valid_r;
  assign out_visited_vertex   = out_vertex_r;
  assign out_has_parent       = out_has_par_r;
  assign out_parent_vertex    = out_par_r;
  assign out_tree_edge_weight = out_w_r;
  assign out_tree_total       = out_tot_r;
  assign out_last_of_run      = out_last_r;

endmodule

### design/prim_mst_ram.sv
`timescale 1ns / 1ps

module prim_mst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/prim_mst_cmp.sv
`timescale 1ns / 1ps

// Shared signed less-than: scan compares a key with the best so far,
// relax compares an edge weight with the neighbor's key.
module prim_mst_cmp #(
  parameter int W = 16
) (
  input  logic                sel_relax,
  input  logic signed [W-1:0] scan_a,
  input  logic signed [W-1:0] scan_b,
  input  logic signed [W-1:0] relax_a,
  input  logic signed [W-1:0] relax_b,
  output logic                lt
);

  logic signed [W-1:0] op_a;
  logic signed [W-1:0] op_b;

  always_comb begin
    op_a = sel_relax ? relax_a : scan_a;
    op_b = sel_relax ? relax_b : scan_b;
    lt   = op_a < op_b;
  end

endmodule

### design/prim_mst_ctrl.sv
`timescale 1ns / 1ps

module prim_mst_ctrl #(
  parameter int VW = 6,
  parameter int AW = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  prim_mst_pkg::stat_t stat,
  input  logic [VW-1:0]       last_idx,
  output logic [VW-1:0]       idx,
  output logic [AW-1:0]       clr_addr,
  output prim_mst_pkg::ctl_t  ctl
);

  import prim_mst_pkg::*;

  state_e        state_r, state_nxt;
  logic [VW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        priority if (stat.acc_clear) begin
          state_nxt = ST_CLEAR;
        end else if (stat.acc_run) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == last_idx) begin
          state_nxt = ST_SCAN_TAIL;
        end
      end
      ST_SCAN_TAIL: state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (!stat.pend_stall) begin
          state_nxt = stat.found ? ST_RELAX : ST_IDLE;
        end
      end
      ST_RELAX: begin
        if (idx_r == last_idx) begin
          state_nxt = ST_RELAX_TAIL;
        end
      end
      ST_RELAX_TAIL: state_nxt = ST_SCAN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Counters: sweep address and vertex index
  always_comb begin
    clr_nxt = (state_r == ST_CLEAR) ? clr_r + 1'b1 : '0;
    idx_nxt = ((state_r == ST_SCAN || state_r == ST_RELAX) && idx_r != last_idx)
              ? idx_r + 1'b1 : '0;
  end

  // Outputs
  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_CLEAR: ctl.clr_we = 1'b1;
      ST_IDLE:  ctl.in_ready = 1'b1;
      ST_SCAN: begin
        ctl.issue_scan = 1'b1;
        ctl.scan_first = (idx_r == '0);
      end
      ST_PUSH:  ctl.push_en = !stat.pend_stall;
      ST_RELAX: ctl.issue_relax = 1'b1;
      ST_SCAN_TAIL, ST_RELAX_TAIL: ctl = '0;
      default:  ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      clr_r   <= clr_nxt;
    end
  end

  assign idx      = idx_r;
  assign clr_addr = clr_r;

endmodule

### design/prim_mst_checker.sv
`timescale 1ns / 1ps

`include "prim_minimum_spanning_tree_core_macros.svh"

module prim_mst_checker (
  input logic                                          clk,
  input logic                                          rst_n,
  input logic                                          in_valid,
  input logic                                          in_ready,
  input logic [prim_mst_pkg::OP_W-1:0]                 in_operation,
  input logic                                          out_valid,
  input logic                                          out_ready,
  input logic [prim_mst_pkg::NODE_W-1:0]               out_visited_vertex,
  input logic                                          out_has_parent,
  input logic [prim_mst_pkg::NODE_W-1:0]               out_parent_vertex,
  input logic signed [prim_mst_pkg::WEIGHT_PORT_W-1:0] out_tree_edge_weight,
  input logic signed [prim_mst_pkg::TOTAL_W-1:0]       out_tree_total,
  input logic                                          out_last_of_run
);

  import prim_mst_pkg::*;

  // stalled result word holds
  `PRIM_MST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_visited_vertex) && $stable(out_has_parent) &&
    $stable(out_parent_vertex) && $stable(out_tree_edge_weight) &&
    $stable(out_tree_total) && $stable(out_last_of_run),
    "result word changed while stalled")

  // edge sweep follows reset
  `PRIM_MST_ASSERT_NOW(a_sweep_after_reset, !$past(rst_n), !in_ready,
    "input ready during reset sweep")

  // a result that is not the last means the run is still going
  `PRIM_MST_ASSERT_NOW(a_busy_mid_run, out_valid && !out_last_of_run, !in_ready,
    "input ready in the middle of a run")

  // clear starts the sweep
  `PRIM_MST_ASSERT_NEXT(a_clear_sweep,
    in_valid && in_ready && in_operation == OP_CLEAR, !in_ready,
    "no sweep after clear")

  // edge loads go back to back
  `PRIM_MST_ASSERT_NEXT(a_add_one_cycle,
    in_valid && in_ready && in_operation == OP_ADD, in_ready,
    "add word held the input")

endmodule

bind prim_minimum_spanning_tree_core prim_mst_checker u_prim_mst_checker (.*);
